FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the sequence match block.
// Depends on nothing; take it in by `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is low.
`define CSM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define CSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/csm_pkg.sv
// Shared types and constants of the contiguous sequence match block.
// Used by the cell, the top level and the checker; no dependencies.
package csm_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned OUT_W         = 8;
  localparam int unsigned PATTERN_DEPTH = 16;

  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END     = 2'd2;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic shift_pat;  // advance the pattern chain
    logic shift_txt;  // advance the text window chain
    logic clear;      // drop all valid bits
  } csm_ctrl_t;

endpackage

FILE: src/contiguous_sequence_match_top.sv
// Top level of the contiguous sequence match block: stream ports, cell chain,
// match and overflow flags, result register. Depends on csm_pkg and csm_cell.
//
//  channel  | dir | tdata                  | tuser      | carries
//  ---------+-----+------------------------+------------+---------------------------
//  s_axis   | in  | [31:0] value           | [1:0] cmd  | pattern, text, end request
//  m_axis   | out | [0] found, [1] overflow| -          | one result per end request
//
// A new request is accepted on each edge while no result waits untaken. The text
// window compare is done by all cells in parallel in the cycle the text word
// shifts in, so the rate is set by the single result register alone.
// A pending result that is not taken stalls further requests only.
// Reset clears all valid bits, the flags and the result register.
module contiguous_sequence_match_top #(
  parameter int unsigned PATTERN_DEPTH = csm_pkg::PATTERN_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [csm_pkg::WORD_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic [csm_pkg::CMD_W-1:0]  s_axis_tuser,   // [1:0] cmd
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [csm_pkg::OUT_W-1:0]  m_axis_tdata    // [0] found, [1] overflow, rest 0
);

  csm_pkg::csm_ctrl_t ctrl;

  // Chain links: index i is the output of cell i.
  logic [csm_pkg::WORD_W-1:0] pat_chain [PATTERN_DEPTH];
  logic [csm_pkg::WORD_W-1:0] txt_chain [PATTERN_DEPTH];
  logic [PATTERN_DEPTH-1:0]   pat_valid;
  logic [PATTERN_DEPTH-1:0]   txt_valid;
  logic [PATTERN_DEPTH-1:0]   hit;

  logic in_fire, is_pat, is_txt, is_end;
  logic overflow_q, overflow_d;
  logic match_q, match_d;
  logic out_valid_q, out_valid_d;
  logic found_q, found_d, out_ovf_q, out_ovf_d;
  logic found_now;

  // Accept while the result register is empty or being drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_pat        = in_fire && (s_axis_tuser == csm_pkg::CMD_PATTERN);
  assign is_txt        = in_fire && (s_axis_tuser == csm_pkg::CMD_TEXT);
  assign is_end        = in_fire && (s_axis_tuser == csm_pkg::CMD_END);

  // The last cell holding a valid pattern word means the store is full.
  assign ctrl.shift_pat = is_pat && !overflow_q && !pat_valid[PATTERN_DEPTH-1];
  assign ctrl.shift_txt = is_txt;
  assign ctrl.clear     = is_end;

  // Newest words enter at cell 0, so cell i pairs pattern word L-1-i with
  // the i-th newest text word.
  for (genvar i = 0; i < PATTERN_DEPTH; i++) begin : g_cell
    logic [csm_pkg::WORD_W-1:0] pat_in, txt_in;
    logic                       pat_vin, txt_vin;
    if (i == 0) begin : g_head
      assign pat_in  = s_axis_tdata;
      assign txt_in  = s_axis_tdata;
      assign pat_vin = 1'b1;
      assign txt_vin = 1'b1;
    end else begin : g_body
      assign pat_in  = pat_chain[i-1];
      assign txt_in  = txt_chain[i-1];
      assign pat_vin = pat_valid[i-1];
      assign txt_vin = txt_valid[i-1];
    end
    csm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .pat_i       (pat_in),
      .pat_valid_i (pat_vin),
      .txt_i       (txt_in),
      .txt_valid_i (txt_vin),
      .pat_o       (pat_chain[i]),
      .pat_valid_o (pat_valid[i]),
      .txt_o       (txt_chain[i]),
      .txt_valid_o (txt_valid[i]),
      .hit_o       (hit[i])
    );
  end

  // A hit needs a non-empty pattern and every used cell agreeing.
  always_comb begin
    overflow_d = overflow_q;
    match_d    = match_q;
    if (is_end) begin
      overflow_d = 1'b0;
      match_d    = 1'b0;
    end else begin
      if (is_pat && (overflow_q || pat_valid[PATTERN_DEPTH-1])) overflow_d = 1'b1;
      if (is_txt && !overflow_q && pat_valid[0] && (&hit))       match_d    = 1'b1;
    end
  end

  // Empty pattern is always found; overflow forces not found.
  assign found_now = !overflow_q && (!pat_valid[0] || match_q);

  always_comb begin
    out_valid_d = out_valid_q;
    found_d     = found_q;
    out_ovf_d   = out_ovf_q;
    if (is_end) begin
      out_valid_d = 1'b1;
      found_d     = found_now;
      out_ovf_d   = overflow_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overflow_q  <= 1'b0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      overflow_q  <= overflow_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(csm_pkg::OUT_W-2){1'b0}}, out_ovf_q, found_q};

endmodule

FILE: src/csm_cell.sv
// One cell of the match chain: a pattern word, a text word and their valid bits.
// Depends on csm_pkg.
module csm_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  csm_pkg::csm_ctrl_t         ctrl_i,
  input  logic [csm_pkg::WORD_W-1:0] pat_i,
  input  logic                       pat_valid_i,
  input  logic [csm_pkg::WORD_W-1:0] txt_i,
  input  logic                       txt_valid_i,
  output logic [csm_pkg::WORD_W-1:0] pat_o,
  output logic                       pat_valid_o,
  output logic [csm_pkg::WORD_W-1:0] txt_o,
  output logic                       txt_valid_o,
  output logic                       hit_o
);

  logic [csm_pkg::WORD_W-1:0] pat_q, txt_q;
  logic                       pat_valid_q, txt_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_valid_q <= 1'b0;
      txt_valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      pat_valid_q <= 1'b0;
      txt_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.shift_pat) pat_valid_q <= pat_valid_i;
      if (ctrl_i.shift_txt) txt_valid_q <= txt_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_pat) pat_q <= pat_i;
    if (ctrl_i.shift_txt) txt_q <= txt_i;
  end

  // Compare against the word that moves in on this text shift; an unused
  // pattern slot always agrees.
  assign hit_o = !pat_valid_q || (txt_valid_i && (pat_q == txt_i));

  assign pat_o       = pat_q;
  assign pat_valid_o = pat_valid_q;
  assign txt_o       = txt_q;
  assign txt_valid_o = txt_valid_q;

endmodule

FILE: src/csm_checker.sv
// Port-level checker for the contiguous sequence match top level, with its bind.
// Depends on csm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [csm_pkg::CMD_W-1:0]  s_axis_tuser,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [csm_pkg::OUT_W-1:0]  m_axis_tdata
);

  logic end_fire;
  logic out_stall;
  logic ovf_out;

  assign end_fire  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == csm_pkg::CMD_END);
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign ovf_out   = m_axis_tvalid && m_axis_tdata[1];

  // A result shows up only after an end request or while an earlier one waits.
  property p_no_invented;
    m_axis_tvalid |-> $past(end_fire || out_stall);
  endproperty

  // Hold a stalled result and its data until it is taken.
  property p_hold_stalled;
    out_stall |=> (m_axis_tvalid && $stable(m_axis_tdata));
  endproperty

  `CSM_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !m_axis_tvalid, "result during reset")
  `CSM_ASSERT(a_end_gives_result, clk_i, rst_ni, end_fire |=> m_axis_tvalid, "end lost")
  `CSM_ASSERT(a_no_invented, clk_i, rst_ni, p_no_invented, "result invented")
  `CSM_ASSERT(a_ovf_not_found, clk_i, rst_ni, ovf_out |-> !m_axis_tdata[0], "found with overflow")
  `CSM_ASSERT(a_hold_stalled, clk_i, rst_ni, p_hold_stalled, "stalled result changed")

endmodule

bind contiguous_sequence_match_top csm_checker u_csm_checker (.*);
